### src/cms_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Content magic sniffer package
// Shared types, class codes and the leading signature tables.
// ----------------------------------------------------------------------------
package cms_pkg;

   localparam int SIG_COUNT  = 5;
   localparam int SIG_MAXLEN = 8;

   typedef logic [2:0] class_type;

   localparam class_type CLASS_TEXT    = 3'd0;
   localparam class_type CLASS_GIF     = 3'd1;
   localparam class_type CLASS_PNG     = 3'd2;
   localparam class_type CLASS_JPEG    = 3'd3;
   localparam class_type CLASS_UNKNOWN = 3'd4;

   // One input beat as it travels from the input register to the scanner.
   typedef struct packed {
      logic [7:0] data_byte;
      logic       final_byte;
   } beat_type;

   // Bit c set: control byte c counts as binary.
   localparam logic [31:0] BINARY_MASK = 32'hF7FF_C9FF;

   localparam logic [3:0] POS_MAX = 4'd15;

   localparam logic [SIG_COUNT-1:0] ALIVE_ALL = '1;

   typedef logic [7:0] sig_row_type [SIG_MAXLEN];

   // Signatures in priority order; unused tail bytes are never compared.
   localparam sig_row_type SIG_BYTES [SIG_COUNT] = '{
      '{8'h47, 8'h49, 8'h46, 8'h38, 8'h37, 8'h61, 8'h00, 8'h00},
      '{8'h47, 8'h49, 8'h46, 8'h38, 8'h39, 8'h61, 8'h00, 8'h00},
      '{8'h89, 8'h50, 8'h4E, 8'h47, 8'h0D, 8'h0A, 8'h1A, 8'h0A},
      '{8'hFF, 8'hDA, 8'hFF, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
      '{8'hFF, 8'hD8, 8'hFF, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00}
   };

   localparam logic [3:0] SIG_LEN [SIG_COUNT] = '{4'd6, 4'd6, 4'd8, 4'd3, 4'd3};

   localparam class_type SIG_CLASS [SIG_COUNT] =
      '{CLASS_GIF, CLASS_GIF, CLASS_PNG, CLASS_JPEG, CLASS_JPEG};

endpackage

### src/cms_scan.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Content magic sniffer scanner
// Holds the per-file state and works out the class of the current beat.
// ----------------------------------------------------------------------------
module cms_scan (
   input  logic               clock,
   input  logic               reset,
   input  logic               step,
   input  cms_pkg::beat_type  beat,
   output cms_pkg::class_type content_class
);
   import cms_pkg::*;

   logic [3:0]           position_ff, position_in;
   logic                 binary_ff, binary_in;
   logic [SIG_COUNT-1:0] alive_ff, alive_in;

   logic                 is_binary;
   logic                 binary_now;
   logic [SIG_COUNT-1:0] alive_now;
   logic [4:0]           count_now;

   assign is_binary  = (beat.data_byte[7:5] == 3'd0) && BINARY_MASK[beat.data_byte[4:0]];
   assign binary_now = binary_ff | is_binary;
   assign count_now  = {1'b0, position_ff} + 5'd1;

   always_comb begin
      alive_now = alive_ff;
      for (int i = 0; i < SIG_COUNT; i++) begin
         if ((position_ff < SIG_LEN[i]) &&
             (beat.data_byte != SIG_BYTES[i][position_ff[2:0]])) begin
            alive_now[i] = 1'b0;
         end
      end
   end

   // Text wins when no binary byte turned up; otherwise the first complete match.
   always_comb begin
      content_class = CLASS_UNKNOWN;
      if (!binary_now) begin
         content_class = CLASS_TEXT;
      end else begin
         for (int i = SIG_COUNT - 1; i >= 0; i--) begin
            if (alive_now[i] && (count_now >= {1'b0, SIG_LEN[i]})) begin
               content_class = SIG_CLASS[i];
            end
         end
      end
   end

   always_comb begin
      position_in = position_ff;
      binary_in   = binary_ff;
      alive_in    = alive_ff;
      if (step) begin
         if (beat.final_byte) begin
            position_in = 4'd0;
            binary_in   = 1'b0;
            alive_in    = ALIVE_ALL;
         end else begin
            position_in = (position_ff < POS_MAX) ? count_now[3:0] : position_ff;
            binary_in   = binary_now;
            alive_in    = alive_now;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         position_ff <= 4'd0;
         binary_ff   <= 1'b0;
         alive_ff    <= ALIVE_ALL;
      end else begin
         position_ff <= position_in;
         binary_ff   <= binary_in;
         alive_ff    <= alive_in;
      end
   end

endmodule

### src/content_magic_sniffer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Content magic sniffer
// Classifies a file as text, GIF, PNG, JPEG or unknown binary from its bytes.
// ----------------------------------------------------------------------------
// The file streams in one byte per request beat, with req_final_byte marking
// the last byte; exactly one response beat follows each last byte and carries
// the class (0 text, 1 GIF, 2 PNG, 3 JPEG, 4 unknown binary). A file is text
// when none of its bytes is a binary control byte (0x00 to 0x1F other than
// tab, line feed, form feed, carriage return and escape); otherwise the first
// leading signature that matched in full decides, GIF87a, GIF89a, PNG, then
// the two JPEG forms. The block takes one byte per clock cycle unless a last
// byte waits behind a stalled response: each beat is captured in an input
// register, the scanner's fixed comparisons and table bit work on it
// combinationally, and the class lands in the response register as the last
// byte leaves the input register.
// Ordinary bytes keep flowing while a finished class waits to be taken; only
// a second last byte waits behind a stalled response.
// ----------------------------------------------------------------------------
module content_magic_sniffer (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [7:0]         req_data_byte,
   input  logic               req_final_byte,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output cms_pkg::class_type rsp_content_class
);
   import cms_pkg::*;

   // Input register: one beat waiting for the scanner.
   logic      in_valid_ff, in_valid_in;
   beat_type  in_beat_ff,  in_beat_in;

   // Response register.
   logic      rsp_valid_ff, rsp_valid_in;
   class_type rsp_class_ff, rsp_class_in;

   logic      out_free;
   logic      advance;
   class_type scan_class;

   // The response register can take a new class when empty or being drained.
   assign out_free = !rsp_valid_ff || !rsp_stall;

   // Non-final beats only touch the scanner state, so they never wait on the
   // response side; a final beat needs room for its class.
   assign advance   = in_valid_ff && (!in_beat_ff.final_byte || out_free);
   assign req_stall = in_valid_ff && !advance;

   always_comb begin
      in_valid_in = in_valid_ff;
      in_beat_in  = in_beat_ff;
      if (!req_stall) begin
         in_valid_in = req_valid;
         if (req_valid) begin
            in_beat_in.data_byte  = req_data_byte;
            in_beat_in.final_byte = req_final_byte;
         end
      end
   end

   cms_scan u_scan (
      .clock         (clock),
      .reset         (reset),
      .step          (advance),
      .beat          (in_beat_ff),
      .content_class (scan_class)
   );

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_class_in = rsp_class_ff;
      if (advance && in_beat_ff.final_byte) begin
         rsp_valid_in = 1'b1;
         rsp_class_in = scan_class;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      in_beat_ff   <= in_beat_in;
      rsp_class_ff <= rsp_class_in;
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_content_class = rsp_class_ff;

`ifndef SYNTHESIS
   // The request side only ever waits for a final beat behind a held class.
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (in_valid_ff && in_beat_ff.final_byte && rsp_valid_ff && rsp_stall))
      else $error("request stalled without a held final beat");

   // Every final beat that leaves the input register yields a response.
   a_final_gives_rsp: assert property (@(posedge clock) disable iff (reset)
      (advance && in_beat_ff.final_byte) |=> rsp_valid_ff)
      else $error("final beat produced no response");

   // Only defined class codes are ever presented.
   a_class_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_class_ff <= CLASS_UNKNOWN))
      else $error("response carries an undefined class code");
`endif

endmodule
